### rtl/fbpa_pkg.sv
// shared types and constants of the fixed block pool allocator
`default_nettype none
package fbpa_pkg;

   localparam int IDX_W = 6;
   localparam int CNT_W = 7;
   localparam int STATUS_W = 2;

   localparam int POOL_ENTRIES_DEFAULT = 64;
   localparam logic [CNT_W-1:0] RESET_ENTRIES = 7'd64;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

   // one classified request waiting for the back end
   typedef struct packed {
      logic is_return;
      logic out_of_range;
      logic [IDX_W-1:0] index;
   } queue_item_type;

endpackage
`default_nettype wire

### rtl/fbpa_front.sv
// request intake: classifies each beat and holds it in a two-entry queue
`default_nettype none
module fbpa_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [7:0] req_tdata,   // item_index[5:0], zero fill
   input  wire logic req_tuser,         // operation
   input  wire logic [fbpa_pkg::CNT_W-1:0] entries,
   output logic q_valid,
   output fbpa_pkg::queue_item_type q_item,
   input  wire logic q_pop
);
   import fbpa_pkg::*;

   queue_item_type item_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic push;
   queue_item_type new_item;

   always_comb begin
      new_item.is_return = req_tuser;
      new_item.index = req_tdata[IDX_W-1:0];
      // range check; user sets the pool size only while idle, unenforced
      new_item.out_of_range = {1'b0, req_tdata[IDX_W-1:0]} >= entries;
   end

   assign req_tready = count_ff != 2'd2;
   assign push = req_tvalid && req_tready;
   assign q_valid = count_ff != 2'd0;
   assign q_item = item_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

### rtl/fbpa_back.sv
// pool engine: returned-entry stack, fresh index counter, low-water mark, result register
`default_nettype none
module fbpa_back #(
   parameter int POOL_ENTRIES = fbpa_pkg::POOL_ENTRIES_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_wen,
   input  wire logic [fbpa_pkg::CNT_W-1:0] csr_wdata,
   output logic [fbpa_pkg::CNT_W-1:0] entries,
   input  wire logic q_valid,
   input  wire fbpa_pkg::queue_item_type q_item,
   output logic q_pop,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [23:0] rsp_tdata,  // granted_index[5:0], free_count[12:6], low_water[19:13]
   output logic [fbpa_pkg::STATUS_W-1:0] rsp_tuser  // status
);
   import fbpa_pkg::*;

   // an entry index is IDX_W bits wide, so the pool never grows past 2**IDX_W
   localparam int CAP_INT = (POOL_ENTRIES < (1 << IDX_W)) ? POOL_ENTRIES : (1 << IDX_W);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(CAP_INT);
   localparam int AW = (CAP_INT > 1) ? $clog2(CAP_INT) : 1;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_POP = 1'b1;

   function automatic logic [CNT_W-1:0] sat_entries(input logic [CNT_W-1:0] value);
      sat_entries = (value > CAP) ? CAP : value;
   endfunction

   logic [IDX_W-1:0] stack_mem [CAP_INT];
   logic [IDX_W-1:0] rd_data_ff;

   logic state_ff, state_in;
   logic [CNT_W-1:0] entries_ff, entries_in;
   logic [CNT_W-1:0] depth_ff, depth_in;
   logic [CNT_W-1:0] fresh_ff, fresh_in;
   logic [CNT_W-1:0] min_ff, min_in;
   logic out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [IDX_W-1:0] grant_ff, grant_in;
   logic [CNT_W-1:0] free_out_ff, free_out_in;
   logic [CNT_W-1:0] low_out_ff, low_out_in;

   logic [CNT_W-1:0] free_now, free_dec, depth_dec;
   logic out_free, mem_we, rd_en;

   assign free_now = depth_ff + (entries_ff - fresh_ff);
   assign free_dec = free_now - 7'd1;
   assign depth_dec = depth_ff - 7'd1;
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      entries_in = entries_ff;
      depth_in = depth_ff;
      fresh_in = fresh_ff;
      min_in = min_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      status_in = status_ff;
      grant_in = grant_ff;
      free_out_in = free_out_ff;
      low_out_in = low_out_ff;
      q_pop = 1'b0;
      mem_we = 1'b0;
      rd_en = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               if (!q_item.is_return) begin
                  if (depth_ff != 7'd0) begin
                     // top of stack comes out of the memory next cycle
                     depth_in = depth_dec;
                     rd_en = 1'b1;
                     state_in = S_POP;
                  end else if (fresh_ff < entries_ff) begin
                     fresh_in = fresh_ff + 7'd1;
                     min_in = (free_dec < min_ff) ? free_dec : min_ff;
                     out_valid_in = 1'b1;
                     status_in = STATUS_OK;
                     grant_in = fresh_ff[IDX_W-1:0];
                     free_out_in = free_dec;
                     low_out_in = (free_dec < min_ff) ? free_dec : min_ff;
                  end else begin
                     out_valid_in = 1'b1;
                     status_in = STATUS_EMPTY;
                     grant_in = '0;
                     free_out_in = free_now;
                     low_out_in = min_ff;
                  end
               end else begin
                  out_valid_in = 1'b1;
                  grant_in = '0;
                  low_out_in = min_ff;
                  if (q_item.out_of_range || free_now >= entries_ff) begin
                     status_in = STATUS_REJECT;
                     free_out_in = free_now;
                  end else begin
                     mem_we = 1'b1;
                     depth_in = depth_ff + 7'd1;
                     status_in = STATUS_OK;
                     free_out_in = free_now + 7'd1;
                  end
               end
            end
         end
         S_POP: begin
            // depth is already decremented, so free_now is the count after the get
            if (out_free) begin
               min_in = (free_now < min_ff) ? free_now : min_ff;
               out_valid_in = 1'b1;
               status_in = STATUS_OK;
               grant_in = rd_data_ff;
               free_out_in = free_now;
               low_out_in = (free_now < min_ff) ? free_now : min_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (csr_wen) begin
         entries_in = sat_entries(csr_wdata);
         depth_in = '0;
         fresh_in = '0;
         min_in = sat_entries(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         entries_ff <= sat_entries(RESET_ENTRIES);
         depth_ff <= '0;
         fresh_ff <= '0;
         min_ff <= sat_entries(RESET_ENTRIES);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         entries_ff <= entries_in;
         depth_ff <= depth_in;
         fresh_ff <= fresh_in;
         min_ff <= min_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      grant_ff <= grant_in;
      free_out_ff <= free_out_in;
      low_out_ff <= low_out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[depth_ff[AW-1:0]] <= q_item.index;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[depth_dec[AW-1:0]];
      end
   end

   assign entries = entries_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser = status_ff;
   assign rsp_tdata = {4'd0, low_out_ff, free_out_ff, grant_ff};

   fresh_in_range: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= entries_ff)
      else $error("fresh index passed the pool size");

   free_in_range: assert property (@(posedge clock) disable iff (reset)
      free_now <= entries_ff)
      else $error("free count above the pool size");

   low_water_bound: assert property (@(posedge clock) disable iff (reset)
      min_ff <= free_now || state_ff == S_POP)
      else $error("low-water mark above the free count");

   pop_holds_queue: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_POP |-> !q_pop)
      else $error("queue popped while a stack read is pending");

endmodule
`default_nettype wire

### rtl/fixed_block_pool_allocator_unit.sv
// top level of the fixed block pool allocator: front intake, queue and pool engine
// path: queue, result register; a get from the returned stack adds its stack read register
// throughput: one beat per cycle while the receiver takes responses, except a get served from
//   the returned stack, which holds the engine in S_POP while the stack memory read completes
// reset: synchronous, clears the queue and the response register, pool set to 64 entries
// a write on the csr port reinitializes the pool at once
`default_nettype none
module fixed_block_pool_allocator_unit #(
   parameter int POOL_ENTRIES = fbpa_pkg::POOL_ENTRIES_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_wen,
   input  wire logic [fbpa_pkg::CNT_W-1:0] csr_wdata,
   input  wire logic req_tvalid,
   output logic req_tready,
   input  wire logic [7:0] req_tdata,   // item_index[5:0], zero fill
   input  wire logic req_tuser,         // operation
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   output logic [23:0] rsp_tdata,  // granted_index[5:0], free_count[12:6], low_water[19:13]
   output logic [fbpa_pkg::STATUS_W-1:0] rsp_tuser  // status
);
   import fbpa_pkg::*;

   logic [CNT_W-1:0] entries;
   logic q_valid;
   logic q_pop;
   queue_item_type q_item;

   fbpa_front u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .entries(entries),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop)
   );

   fbpa_back #(
      .POOL_ENTRIES(POOL_ENTRIES)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .csr_wen(csr_wen),
      .csr_wdata(csr_wdata),
      .entries(entries),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

endmodule
`default_nettype wire

### sim/fixed_block_pool_allocator_unit_tb.sv
// self-checking testbench of the fixed block pool allocator: directed and random gets and returns
`timescale 1ns / 1ps
module fixed_block_pool_allocator_unit_tb;
   import fbpa_pkg::*;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_RETURN = 1'b1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 900;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0] granted;
      logic [CNT_W-1:0] free_count;
      logic [CNT_W-1:0] low_water;
   } pool_result_type;

   // shadow of the pool plus the queue of responses still owed by the block
   class pool_scoreboard;
      logic [CNT_W-1:0] size_now;
      logic [CNT_W-1:0] stack_top;
      logic [CNT_W-1:0] next_fresh;
      logic [CNT_W-1:0] low_mark;
      logic [IDX_W-1:0] freed_stack [POOL_ENTRIES_DEFAULT];
      logic [IDX_W-1:0] handed_out [$];
      pool_result_type awaited [$];
      int unsigned errors;

      function new();
         errors = 0;
         foreach (freed_stack[i]) freed_stack[i] = '0;
         configure(RESET_ENTRIES);
      endfunction

      function void configure(logic [CNT_W-1:0] value);
         size_now = (value > POOL_ENTRIES_DEFAULT) ? CNT_W'(POOL_ENTRIES_DEFAULT) : value;
         stack_top = '0;
         next_fresh = '0;
         low_mark = size_now;
         handed_out.delete();
      endfunction

      function logic [CNT_W-1:0] free_entries();
         return stack_top + (size_now - next_fresh);
      endfunction

      function void note_request(logic op, logic [IDX_W-1:0] idx);
         pool_result_type r;
         r = '0;
         r.status = STATUS_OK;
         if (op == OP_GET) begin
            if (stack_top != 0) begin
               stack_top--;
               r.granted = freed_stack[stack_top[IDX_W-1:0]];
            end else if (next_fresh < size_now) begin
               r.granted = next_fresh[IDX_W-1:0];
               next_fresh++;
            end else begin
               r.status = STATUS_EMPTY;
            end
            if (r.status == STATUS_OK) begin
               handed_out.push_back(r.granted);
               if (free_entries() < low_mark) low_mark = free_entries();
            end
         end else begin
            if ({1'b0, idx} >= size_now || free_entries() >= size_now
                || stack_top >= POOL_ENTRIES_DEFAULT) begin
               r.status = STATUS_REJECT;
            end else begin
               freed_stack[stack_top[IDX_W-1:0]] = idx;
               stack_top++;
               for (int i = 0; i < handed_out.size(); i++) begin
                  if (handed_out[i] == idx) begin
                     handed_out.delete(i);
                     break;
                  end
               end
            end
         end
         r.free_count = free_entries();
         r.low_water = low_mark;
         awaited.push_back(r);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned seen);
         if (want != seen) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
            errors++;
         end
      endfunction

      function void check_response(pool_result_type got);
         pool_result_type want;
         if (awaited.size() == 0) begin
            $display("%0t: response beat with nothing awaited, actual %h", $time, got);
            errors++;
            return;
         end
         want = awaited.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("granted_index", want.granted, got.granted);
         compare_field("free_count", want.free_count, got.free_count);
         compare_field("low_water", want.low_water, got.low_water);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wen = 1'b0;
   logic [CNT_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [STATUS_W-1:0] rsp_tuser;

   pool_scoreboard sb = new();
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int stall_mode = 0;
   logic [7:0] stall_mask = 8'hff;
   logic [2:0] stall_step = '0;

   fixed_block_pool_allocator_unit DUT (
      .clock(clock),
      .reset(reset),
      .csr_wen(csr_wen),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout", $time);
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata[IDX_W-1:0]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response({rsp_tuser, rsp_tdata[5:0], rsp_tdata[12:6], rsp_tdata[19:13]});
      end
   end

   // receiver back-pressure, one of three patterns chosen per phase
   always @(negedge clock) begin
      stall_step <= stall_step + 1'b1;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= stall_mask[stall_step];
      endcase
   end

   task automatic send_beat(logic op, logic [IDX_W-1:0] idx);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {2'b00, idx};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic pause_sender(int unsigned cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_pool_size(logic [CNT_W-1:0] value);
      wait_drain();
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      sb.configure(value);
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic run_random_phase(int unsigned count, int unsigned get_pct);
      int unsigned burst;
      int unsigned pick;
      logic op;
      logic [IDX_W-1:0] idx;
      burst = $urandom_range(1, 16);
      repeat (count) begin
         op = ($urandom_range(0, 99) < get_pct) ? OP_GET : OP_RETURN;
         idx = IDX_W'($urandom_range(0, 63));
         pick = $urandom_range(0, 9);
         // returns mostly give back something held, sometimes any in-range or wild index
         if (op == OP_RETURN && pick < 7 && sb.handed_out.size() > 0)
            idx = sb.handed_out[$urandom_range(0, sb.handed_out.size() - 1)];
         else if (op == OP_RETURN && pick < 9 && sb.size_now > 0)
            idx = IDX_W'($urandom_range(0, sb.size_now - 1));
         send_beat(op, idx);
         if (--burst == 0) begin
            pause_sender($urandom_range(0, 4));
            burst = $urandom_range(1, 16);
         end
      end
   endtask

   initial begin
      logic [CNT_W-1:0] size_pick;
      int unsigned pick;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // pool of 64 after reset
      send_beat(OP_RETURN, 6'd0);
      send_beat(OP_GET, 6'd17);
      send_beat(OP_GET, 6'd63);
      send_beat(OP_RETURN, 6'd63);
      send_beat(OP_RETURN, 6'd1);
      send_beat(OP_GET, 6'd0);
      send_beat(OP_GET, 6'd0);
      send_beat(OP_GET, 6'd0);

      // tiny pool: out of range, exhaustion, reuse
      write_pool_size(7'd3);
      send_beat(OP_GET, 6'd0);
      send_beat(OP_RETURN, 6'd3);
      send_beat(OP_RETURN, 6'd63);
      send_beat(OP_GET, 6'd0);
      send_beat(OP_GET, 6'd0);
      send_beat(OP_GET, 6'd0);
      send_beat(OP_RETURN, 6'd2);
      send_beat(OP_GET, 6'd0);

      // empty pool
      write_pool_size(7'd0);
      send_beat(OP_GET, 6'd0);
      send_beat(OP_RETURN, 6'd0);

      // oversize writes saturate
      write_pool_size(7'd127);
      send_beat(OP_RETURN, 6'd63);
      send_beat(OP_GET, 6'd0);
      write_pool_size(7'd65);
      send_beat(OP_GET, 6'd0);

      write_pool_size(7'd1);
      send_beat(OP_GET, 6'd0);
      send_beat(OP_GET, 6'd0);
      send_beat(OP_RETURN, 6'd0);
      send_beat(OP_RETURN, 6'd0);

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) size_pick = CNT_W'($urandom_range(1, 8));
         else if (pick < 9) size_pick = CNT_W'($urandom_range(9, 64));
         else begin
            case ($urandom_range(0, 3))
               0: size_pick = 7'd0;
               1: size_pick = 7'd64;
               2: size_pick = 7'd127;
               default: size_pick = CNT_W'($urandom_range(65, 127));
            endcase
         end
         wait_drain();
         stall_mode = $urandom_range(0, 2);
         stall_mask = 8'($urandom_range(0, 255)) | 8'h01;
         write_pool_size(size_pick);
         run_random_phase($urandom_range(30, 120), $urandom_range(35, 65));
      end

      wait_drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
